// ----- sv/vtis_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vtis_pkg;

  typedef logic [7:0] byte_t;

  // Edit modes (edit_mode register)
  localparam logic [1:0] MODE_PASS  = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_STRIP = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;   // no edit defined, handled as pass

  // Configuration register indexes
  localparam logic [1:0] REG_EDIT_MODE = 2'd0;
  localparam logic [1:0] REG_VLAN_ID   = 2'd1;
  localparam logic [1:0] REG_PRIORITY  = 2'd2;
  localparam logic [1:0] REG_TPID      = 2'd3;

  localparam int unsigned CFG_WIDTH  = 16;
  localparam int unsigned PEND_DEPTH = 6;   // most bytes one item can produce
  localparam int unsigned CNT_W      = $clog2(PEND_DEPTH + 1);

  localparam logic [15:0] TPID_RESET = 16'h8100;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;

  // Byte positions of interest in the frame header
  localparam logic [4:0] POS_TYPE_HI = 5'd12;
  localparam logic [4:0] POS_TYPE_LO = 5'd13;
  localparam logic [4:0] POS_TCI_HI  = 5'd14;
  localparam logic [4:0] POS_TCI_LO  = 5'd15;
  localparam logic [4:0] POS_SAT     = 5'd16;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input byte_t b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/vlan_tag_insert_strip_fcs.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake             | Fields (lowest bit first)
// --------+-----------------------+--------------------------------------------------
// in      | in_tvalid/in_tready   | tdata: in_byte; tlast: in_last
// out     | out_tvalid/out_tready | tdata: byte, fcs; tuser: empty, changed; tlast: last
// cfg     | cfg_we                | cfg_addr picks edit_mode, vlan_id, priority_cfg, tpid
//
// One input item per cycle while unstalled. Each accepted item is decoded into a
// pending list of 0..6 bytes that drains one byte per cycle, while unstalled, into the
// output register, where the CRC is updated. The ethertype low byte releases the held
// high byte (six bytes on tag insertion); in_tready stays low until the last leaves.
// Synchronous active-low reset clears frame state, the pending list and out_tvalid.
// out_tready low stalls the output register and, through the pending list, input.

module vlan_tag_insert_strip_fcs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // in_byte[7:0]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // out_byte[7:0], frame_fcs[39:8]
  output logic [1:0]       out_tuser,  // out_empty[0], frame_changed[1]
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [vtis_pkg::CFG_WIDTH-1:0] cfg_wdata
);

  // configuration registers
  logic [1:0]  edit_mode_r;
  logic [11:0] vlan_id_r;
  logic [2:0]  prio_r;
  logic [15:0] tpid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edit_mode_r <= vtis_pkg::MODE_PASS;
      vlan_id_r   <= '0;
      prio_r      <= '0;
      tpid_r      <= vtis_pkg::TPID_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        vtis_pkg::REG_EDIT_MODE: edit_mode_r <= cfg_wdata[1:0];
        vtis_pkg::REG_VLAN_ID:   vlan_id_r   <= cfg_wdata[11:0];
        vtis_pkg::REG_PRIORITY:  prio_r      <= cfg_wdata[2:0];
        vtis_pkg::REG_TPID:      tpid_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // per-frame state
  logic [4:0]  pos_r;
  logic [7:0]  held_r;
  logic        tagged_r;
  logic        modified_r;
  logic [1:0]  mode_r;

  // pending list: bytes of the accepted item, entry 0 leaves next
  vtis_pkg::byte_t         pend_r [vtis_pkg::PEND_DEPTH];
  logic [vtis_pkg::CNT_W-1:0] pend_cnt_r;
  logic                    pend_last_r;   // item carried in_last
  logic                    pend_mod_r;    // frame_modified after that item

  // output register
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_empty_r;
  logic        out_last_r;
  logic [31:0] out_fcs_r;
  logic        out_chg_r;
  logic [31:0] crc_r;

  // drain control
  logic out_free, pend_busy, move, move_final, in_acc;
  assign out_free   = !out_valid_r || out_tready;
  assign pend_busy  = (pend_cnt_r != '0) || pend_last_r;
  assign move       = pend_busy && out_free;
  // last entry (or the bare frame close) leaves this cycle
  assign move_final = move && (pend_cnt_r <= vtis_pkg::CNT_W'(1));
  assign in_tready  = !pend_busy || move_final;
  assign in_acc     = in_tvalid && in_tready;

  // decode of the incoming item
  vtis_pkg::byte_t         ld_b [vtis_pkg::PEND_DEPTH];
  logic [vtis_pkg::CNT_W-1:0] ld_cnt;
  logic        ld_mod;
  logic        tag_hit;
  logic [1:0]  cur_mode;
  logic [15:0] tci;
  logic [7:0]  b;

  always_comb begin
    b        = in_tdata;
    tci      = {prio_r, 1'b0, vlan_id_r};
    cur_mode = mode_r;
    if (pos_r == '0) begin
      cur_mode = (edit_mode_r == vtis_pkg::MODE_RSVD) ? vtis_pkg::MODE_PASS : edit_mode_r;
    end
    tag_hit = ({held_r, b} == tpid_r);
    for (int i = 0; i < vtis_pkg::PEND_DEPTH; i++) begin
      ld_b[i] = '0;
    end
    ld_b[0] = b;
    ld_cnt  = vtis_pkg::CNT_W'(1);
    ld_mod  = modified_r;
    if (pos_r == vtis_pkg::POS_TYPE_HI) begin
      // ethertype high byte waits for its partner unless the frame ends here
      ld_cnt = in_tlast ? vtis_pkg::CNT_W'(1) : '0;
    end else if (pos_r == vtis_pkg::POS_TYPE_LO) begin
      if (cur_mode == vtis_pkg::MODE_ADD && !tag_hit) begin
        ld_b[0] = tpid_r[15:8];
        ld_b[1] = tpid_r[7:0];
        ld_b[2] = tci[15:8];
        ld_b[3] = tci[7:0];
        ld_b[4] = held_r;
        ld_b[5] = b;
        ld_cnt  = vtis_pkg::CNT_W'(6);
        ld_mod  = 1'b1;
      end else if (cur_mode == vtis_pkg::MODE_STRIP && tag_hit) begin
        ld_cnt = '0;
        ld_mod = 1'b1;
      end else begin
        ld_b[0] = held_r;
        ld_b[1] = b;
        ld_cnt  = vtis_pkg::CNT_W'(2);
      end
    end else if (pos_r == vtis_pkg::POS_TCI_HI || pos_r == vtis_pkg::POS_TCI_LO) begin
      if (cur_mode == vtis_pkg::MODE_ADD && tagged_r) begin
        ld_b[0] = (pos_r == vtis_pkg::POS_TCI_HI) ? tci[15:8] : tci[7:0];
        ld_mod  = 1'b1;
      end else if (cur_mode == vtis_pkg::MODE_STRIP && tagged_r) begin
        ld_cnt = '0;
      end
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      held_r     <= '0;
      tagged_r   <= 1'b0;
      modified_r <= 1'b0;
      mode_r     <= vtis_pkg::MODE_PASS;
    end else if (in_acc) begin
      if (in_tlast) begin
        pos_r      <= '0;
        held_r     <= '0;
        tagged_r   <= 1'b0;
        modified_r <= 1'b0;
        mode_r     <= vtis_pkg::MODE_PASS;
      end else begin
        pos_r      <= (pos_r < vtis_pkg::POS_SAT) ? pos_r + 5'd1 : vtis_pkg::POS_SAT;
        modified_r <= ld_mod;
        mode_r     <= cur_mode;
        if (pos_r == vtis_pkg::POS_TYPE_HI) held_r <= b;
        if (pos_r == vtis_pkg::POS_TYPE_LO) tagged_r <= tag_hit;
      end
    end
  end

  // pending list control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r  <= '0;
      pend_last_r <= 1'b0;
      pend_mod_r  <= 1'b0;
    end else if (in_acc) begin
      pend_cnt_r  <= ld_cnt;
      pend_last_r <= in_tlast;
      pend_mod_r  <= ld_mod;
    end else if (move) begin
      if (pend_cnt_r != '0) pend_cnt_r <= pend_cnt_r - vtis_pkg::CNT_W'(1);
      if (move_final) pend_last_r <= 1'b0;
    end
  end

  // pending payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < vtis_pkg::PEND_DEPTH; i++) pend_r[i] <= ld_b[i];
    end else if (move) begin
      for (int i = 0; i < vtis_pkg::PEND_DEPTH - 1; i++) pend_r[i] <= pend_r[i+1];
    end
  end

  // output stage with running CRC
  logic [31:0] crc_nxt;
  logic        close_only;
  logic        end_here;
  assign crc_nxt    = vtis_pkg::crc32_byte(crc_r, pend_r[0]);
  assign close_only = (pend_cnt_r == '0);          // frame ended inside dropped bytes
  assign end_here   = move_final && pend_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      crc_r       <= vtis_pkg::CRC_INIT;
    end else if (move) begin
      out_valid_r <= 1'b1;
      if (end_here) begin
        crc_r <= vtis_pkg::CRC_INIT;
      end else if (!close_only) begin
        crc_r <= crc_nxt;
      end
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte_r  <= close_only ? 8'd0 : pend_r[0];
      out_empty_r <= close_only;
      out_last_r  <= end_here;
      out_fcs_r   <= end_here ? ~(close_only ? crc_r : crc_nxt) : 32'd0;
      out_chg_r   <= end_here && pend_mod_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_fcs_r, out_byte_r};
  assign out_tuser  = {out_chg_r, out_empty_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ----- sv/vtis_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vtis_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // an empty item only ever closes a frame
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && out_tdata[7:0] == 8'd0)
    else $error("empty item not closing a frame");

  // fcs and changed flag only on the frame's last item
  a_mid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[39:8] == 32'd0 && !out_tuser[1])
    else $error("frame summary on a mid-frame item");

  // two empty closes never follow back to back
  a_no_double_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser[0] |=> !(out_tvalid && out_tuser[0] &&
                                                    $past(out_tready)))
    else $error("consecutive empty items");

endmodule

bind vlan_tag_insert_strip_fcs vtis_checker u_vtis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
